// ===== src/alfp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the linked list with free pool: action and status codes,
// command and result structs. No dependencies.
package alfp_pkg;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POOL_FULL  = 2'd1;
  localparam logic [1:0] ST_LIST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD_PRED   = 2'd3;

  // fixed port field widths
  localparam int IDX_W  = 7;
  localparam int ITEM_W = 16;

  typedef struct packed {
    logic [1:0]               action;
    logic [IDX_W-1:0]         pred_node;
    logic signed [ITEM_W-1:0] item;
    logic [IDX_W-1:0]         read_node;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [IDX_W-1:0]         node_index;
    logic signed [ITEM_W-1:0] read_data;
    logic [IDX_W-1:0]         read_next;
    logic [IDX_W-1:0]         list_head;
    logic                     list_empty;
    logic                     pool_full;
  } result_t;

endpackage

// ===== src/array_linked_list_with_free_pool_top.sv =====
`timescale 1ns / 1ps
// Top level of the linked list with free pool: stream ports, link and data
// RAMs, sequencer, output register. Uses alfp_pkg, alfp_ram, alfp_ctrl.
//
//  channel  | dir | tdata (low bit first)                     | tuser
//  s_axis   | in  | pred_node[6:0] item[15:0] read_node[6:0]  | action[1:0]
//  m_axis   | out | node_index[6:0] read_data[15:0]           | status[1:0]
//           |     |  read_next[6:0] list_head[6:0]            |
//           |     |  list_empty pool_full                     |
//
// Path per beat: straight to the result for an action refused at once, a
// no-op or a read of node 0 or past the pool; through S_A1 for a read, an
// insert at the head, a delete of the head or a delete refused because the
// predecessor is a tail; through S_A1, S_A2 and S_A3 for an insert or
// delete after a given node. The path is set by the single write port of
// the link RAM and its registered read: each dependent link read needs a state.
// After reset a clearing pass over all NODES+1 entries loads the pool chain;
// s_axis_tready stays low during it.
// A finished result sits in the output register; the next beat is taken
// while it waits, and the sequencer holds only if a second result is ready.
module array_linked_list_with_free_pool_top #(
  parameter int NODES = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pred_node, item, read_node, pad
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // node_index, read_data, read_next,
                                      // list_head, list_empty, pool_full, pad
  output logic [1:0]  m_axis_tuser    // status
);
  import alfp_pkg::*;

  localparam int IW = $clog2(NODES + 1);

  cmd_t    cmd;
  result_t res, out_res;
  logic    res_valid, res_ready;
  logic    out_valid;

  logic                  link_we, data_we;
  logic [IW-1:0]         waddr, raddr;
  logic [IW-1:0]         link_wdata, link_rdata;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

  // unpack the input beat
  always_comb begin
    cmd.action    = s_axis_tuser;
    cmd.pred_node = s_axis_tdata[6:0];
    cmd.item      = s_axis_tdata[22:7];
    cmd.read_node = s_axis_tdata[29:23];
  end

  alfp_ctrl #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s_axis_tvalid),
    .cmd_ready  (s_axis_tready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .link_we    (link_we),
    .data_we    (data_we),
    .waddr      (waddr),
    .raddr      (raddr),
    .link_wdata (link_wdata),
    .data_wdata (data_wdata),
    .link_rdata (link_rdata),
    .data_rdata (data_rdata)
  );

  // link store: entry 0 is the null node and stays 0
  alfp_ram #(
    .WIDTH (IW),
    .DEPTH (NODES + 1)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  // data store, same addressing as the link store
  alfp_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NODES + 1)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data_wdata),
    .raddr (raddr),
    .rdata (data_rdata)
  );

  // output register: frees the sequencer as soon as the result is parked
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {1'b0, out_res.pool_full, out_res.list_empty,
                          out_res.list_head, out_res.read_next,
                          out_res.read_data, out_res.node_index};

endmodule

// ===== src/alfp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module alfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/alfp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the linked list: head and free-head registers, clearing pass,
// read-modify-write of the link and data RAMs. Uses alfp_pkg.
module alfp_ctrl #(
  parameter int NODES = 64,
  parameter int DATA_WIDTH = 16,
  localparam int IW = $clog2(NODES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  alfp_pkg::cmd_t        cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output alfp_pkg::result_t     res,
  output logic                  link_we,
  output logic                  data_we,
  output logic [IW-1:0]         waddr,
  output logic [IW-1:0]         raddr,
  output logic [IW-1:0]         link_wdata,
  output logic [DATA_WIDTH-1:0] data_wdata,
  input  logic [IW-1:0]         link_rdata,
  input  logic [DATA_WIDTH-1:0] data_rdata
);
  import alfp_pkg::*;

  localparam int CW = (IW > IDX_W) ? IW : IDX_W;
  localparam int MW = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;
  localparam logic [IW-1:0] LAST = IW'(NODES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_A1   = 3'd2;
  localparam logic [2:0] S_A2   = 3'd3;
  localparam logic [2:0] S_A3   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state, state_next;
  logic [IW-1:0]         clr, clr_next;
  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         free_hd, free_hd_next;
  logic [1:0]            act, act_next;
  logic [IW-1:0]         pred, pred_next;
  logic                  pzero, pzero_next;
  logic [DATA_WIDTH-1:0] item_d, item_d_next;
  logic [IW-1:0]         tnode, tnode_next;
  logic [IW-1:0]         lnk, lnk_next;
  logic [1:0]            st, st_next;
  logic [IW-1:0]         nidx, nidx_next;
  logic [ITEM_W-1:0]     rd16, rd16_next;
  logic [IW-1:0]         rnx, rnx_next;

  logic [CW-1:0] pred_w, rn_w, nidx_w, rnx_w, head_w;
  logic          pred_ok, rn_ok;
  logic [MW-1:0] rdata_w;

  assign pred_w  = CW'(cmd.pred_node);
  assign rn_w    = CW'(cmd.read_node);
  assign pred_ok = pred_w <= CW'(NODES);
  assign rn_ok   = (rn_w <= CW'(NODES)) && (rn_w != '0);
  assign rdata_w = MW'(data_rdata);

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next   = state;
    clr_next     = clr;
    head_next    = head;
    free_hd_next = free_hd;
    act_next     = act;
    pred_next    = pred;
    pzero_next   = pzero;
    item_d_next  = item_d;
    tnode_next   = tnode;
    lnk_next     = lnk;
    st_next      = st;
    nidx_next    = nidx;
    rd16_next    = rd16;
    rnx_next     = rnx;
    link_we      = 1'b0;
    data_we      = 1'b0;
    waddr        = tnode;
    raddr        = tnode;
    link_wdata   = free_hd;
    data_wdata   = '1;

    unique case (state)
      S_CLR: begin
        // entry i links to i+1 with data -1; entry 0 and the last node hold 0
        link_we  = 1'b1;
        data_we  = 1'b1;
        waddr    = clr;
        clr_next = clr + IW'(1);
        if (clr == '0 || clr == LAST) begin
          link_wdata = '0;
          data_wdata = '0;
        end else begin
          link_wdata = clr + IW'(1);
          data_wdata = '1;
        end
        if (clr == LAST) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          act_next    = cmd.action;
          pred_next   = IW'(pred_w);
          pzero_next  = (cmd.pred_node == '0);
          item_d_next = DATA_WIDTH'(cmd.item);
          st_next     = ST_OK;
          nidx_next   = '0;
          rd16_next   = '0;
          rnx_next    = '0;
          state_next  = S_DONE;
          unique case (cmd.action)
            ACT_INSERT: begin
              if (free_hd == '0) begin
                st_next = ST_POOL_FULL;
              end else if (!pred_ok) begin
                st_next = ST_BAD_PRED;
              end else begin
                raddr      = free_hd;
                tnode_next = free_hd;
                state_next = S_A1;
              end
            end
            ACT_DELETE: begin
              if (head == '0) begin
                st_next = ST_LIST_EMPTY;
              end else if (!pred_ok) begin
                st_next = ST_BAD_PRED;
              end else if (cmd.pred_node == '0) begin
                raddr      = head;
                tnode_next = head;
                state_next = S_A1;
              end else begin
                raddr      = IW'(pred_w);
                state_next = S_A1;
              end
            end
            ACT_READ: begin
              if (rn_ok) begin
                raddr      = IW'(rn_w);
                state_next = S_A1;
              end
            end
            ACT_NOP: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_A1: begin
        state_next = S_DONE;
        unique case (act)
          ACT_INSERT: begin
            if (pzero) begin
              link_we      = 1'b1;
              data_we      = 1'b1;
              link_wdata   = head;
              data_wdata   = item_d;
              head_next    = tnode;
              free_hd_next = link_rdata;
              nidx_next    = tnode;
            end else begin
              lnk_next   = link_rdata;
              raddr      = pred;
              state_next = S_A2;
            end
          end
          ACT_DELETE: begin
            if (pzero) begin
              // unlink head and push it onto the free list
              link_we      = 1'b1;
              data_we      = 1'b1;
              head_next    = link_rdata;
              free_hd_next = tnode;
              nidx_next    = tnode;
            end else if (link_rdata == '0) begin
              st_next = ST_BAD_PRED;
            end else begin
              tnode_next = link_rdata;
              raddr      = link_rdata;
              state_next = S_A2;
            end
          end
          default: begin
            rnx_next  = link_rdata;
            rd16_next = rdata_w[ITEM_W-1:0];
          end
        endcase
      end

      S_A2: begin
        state_next = S_A3;
        link_we    = 1'b1;
        link_wdata = link_rdata;
        if (act == ACT_INSERT) begin
          data_we      = 1'b1;
          data_wdata   = item_d;
          free_hd_next = lnk;
        end else begin
          waddr = pred;
        end
      end

      S_A3: begin
        state_next = S_DONE;
        link_we    = 1'b1;
        nidx_next  = tnode;
        if (act == ACT_INSERT) begin
          waddr      = pred;
          link_wdata = tnode;
        end else begin
          data_we      = 1'b1;
          free_hd_next = tnode;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr     <= '0;
      head    <= '0;
      free_hd <= IW'(1);
    end else begin
      state   <= state_next;
      clr     <= clr_next;
      head    <= head_next;
      free_hd <= free_hd_next;
    end
    act    <= act_next;
    pred   <= pred_next;
    pzero  <= pzero_next;
    item_d <= item_d_next;
    tnode  <= tnode_next;
    lnk    <= lnk_next;
    st     <= st_next;
    nidx   <= nidx_next;
    rd16   <= rd16_next;
    rnx    <= rnx_next;
  end

  assign nidx_w = CW'(nidx);
  assign rnx_w  = CW'(rnx);
  assign head_w = CW'(head);

  always_comb begin
    res.status     = st;
    res.node_index = nidx_w[IDX_W-1:0];
    res.read_data  = rd16;
    res.read_next  = rnx_w[IDX_W-1:0];
    res.list_head  = head_w[IDX_W-1:0];
    res.list_empty = (head == '0);
    res.pool_full  = (free_hd == '0);
  end

  // no RAM write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!link_we && !data_we))
    else $error("RAM write while idle");

  // a node is reported only on success
  a_node_on_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.node_index != '0) |-> (res.status == ST_OK))
    else $error("node index with error status");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_POOL_FULL) |-> res.pool_full)
    else $error("pool full status without full flag");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_LIST_EMPTY) |-> res.list_empty)
    else $error("list empty status without empty flag");

endmodule
